>>> design/bmec_pkg.sv
// shared types and constants for the binary map erode and crop unit
package bmec_pkg;

   localparam int DEF_MAX_ROWS = 16;
   localparam int DEF_MAX_COLS = 16;

   localparam int DIM_W = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   localparam logic [DIM_W-1:0] DIM_RESET = 5'd10;

   // register index taken from address bit 2
   localparam logic CSR_IDX_ROWS = 1'b0;
   localparam logic CSR_IDX_COLS = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // a land cell survives with at most this many sea neighbors
   localparam logic [2:0] SEA_MAX = 3'd2;

   typedef struct packed {
      logic load;
      logic erode_start;
      logic erode_step;
      logic scan_step;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic frame_full;
      logic erode_last;
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage

>>> design/bmec_ctrl.sv
// request sequencer for the binary map erode and crop unit
module bmec_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_op,
   input  bmec_pkg::sts_type sts,
   output logic              req_tready,
   output bmec_pkg::cmd_type cmd
);
   import bmec_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_ERODE,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  cmd.load = 1'b1;
                  if (sts.frame_full) begin
                     cmd.erode_start = 1'b1;
                     state_in        = ST_ERODE;
                  end
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_ERODE: begin
            cmd.erode_step = 1'b1;
            if (sts.erode_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/bmec_dp.sv
// map storage, erosion sweep, bounding box and cropped readout
module bmec_dp #(
   parameter int MAX_ROWS = bmec_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bmec_pkg::DEF_MAX_COLS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bmec_pkg::DIM_W-1:0] cfg_rows,
   input  logic [bmec_pkg::DIM_W-1:0] cfg_cols,
   input  logic                       req_land,
   input  bmec_pkg::cmd_type          cmd,
   output bmec_pkg::sts_type          sts,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_cell,
   output logic                       rsp_eor,
   output logic                       rsp_last,
   output logic                       rsp_empty
);
   import bmec_pkg::*;

   localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_CW = $clog2(MAX_ROWS + 2);
   localparam int COL_CW = $clog2(MAX_COLS + 1);

   logic [MAX_COLS-1:0] land_mem [MAX_ROWS];
   logic [MAX_COLS-1:0] surv_mem [MAX_ROWS];

   logic [ROW_AW-1:0]   load_row_ff, load_row_in;
   logic [COL_AW-1:0]   load_col_ff, load_col_in;
   logic [ROW_CW-1:0]   er_rows_ff, er_rows_in;
   logic [COL_CW-1:0]   er_cols_ff, er_cols_in;
   logic [MAX_COLS-1:0] col_mask_ff, col_mask_in;
   logic [ROW_CW-1:0]   step_ff, step_in;
   logic [MAX_COLS-1:0] up_ff, up_in;
   logic [MAX_COLS-1:0] mid_ff, mid_in;
   logic [MAX_COLS-1:0] land_rd_ff;
   logic [MAX_COLS-1:0] union_ff, union_in;
   logic                box_valid_ff, box_valid_in;
   logic [ROW_AW-1:0]   row_lo_ff, row_lo_in;
   logic [ROW_AW-1:0]   row_hi_ff, row_hi_in;
   logic [COL_AW-1:0]   scan_ff, scan_in;
   logic                col_found_ff, col_found_in;
   logic [COL_AW-1:0]   col_lo_ff, col_lo_in;
   logic [COL_AW-1:0]   col_hi_ff, col_hi_in;
   logic                frame_ready_ff, frame_ready_in;
   logic [ROW_AW-1:0]   read_row_ff, read_row_in;
   logic [COL_AW-1:0]   read_col_ff, read_col_in;
   logic [MAX_COLS-1:0] surv_rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_cell_ff, rsp_cell_in;
   logic                rsp_eor_ff, rsp_eor_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic [ROW_CW-1:0]   eff_rows;
   logic [COL_CW-1:0]   eff_cols;
   logic [7:0]          col_next;
   logic [7:0]          row_next;
   logic                wrap;
   logic                frame_full;

   logic                rd_en;
   logic                calc_en;
   logic [ROW_CW-1:0]   calc_row;
   logic [MAX_COLS-1:0] up_row;
   logic [MAX_COLS-1:0] down_row;
   logic [MAX_COLS+1:0] mid_pad;
   logic [MAX_COLS-1:0] surv_row;
   logic                erode_last;

   logic                hit;
   logic [COL_AW-1:0]   col_lo_nx;
   logic [COL_AW-1:0]   col_hi_nx;
   logic                scan_last;

   logic                empty;
   logic                rd_cell;
   logic                eor;
   logic                fin;

   // clamp dimensions to 1..max
   always_comb begin
      if (cfg_rows == '0) begin
         eff_rows = ROW_CW'(1);
      end else if (8'(cfg_rows) > 8'(MAX_ROWS)) begin
         eff_rows = ROW_CW'(MAX_ROWS);
      end else begin
         eff_rows = ROW_CW'(cfg_rows);
      end
      if (cfg_cols == '0) begin
         eff_cols = COL_CW'(1);
      end else if (8'(cfg_cols) > 8'(MAX_COLS)) begin
         eff_cols = COL_CW'(MAX_COLS);
      end else begin
         eff_cols = COL_CW'(cfg_cols);
      end
   end

   // raster position of the next load
   assign col_next   = 8'(load_col_ff) + 8'd1;
   assign wrap       = col_next >= 8'(eff_cols);
   assign row_next   = wrap ? (8'(load_row_ff) + 8'd1) : 8'(load_row_ff);
   assign frame_full = row_next >= 8'(eff_rows);

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         col_mask_in[c] = 8'(c) < 8'(eff_cols);
      end
   end

   // erosion sweep: row step-2 is computed from a three row window
   assign rd_en    = cmd.erode_step && (step_ff < er_rows_ff);
   assign calc_en  = cmd.erode_step && (step_ff >= ROW_CW'(2));
   assign calc_row = step_ff - ROW_CW'(2);
   assign up_row   = (step_ff == ROW_CW'(2)) ? '0 : up_ff;
   assign down_row = (step_ff <= er_rows_ff) ? (land_rd_ff & col_mask_ff) : '0;
   assign mid_pad  = {1'b0, mid_ff, 1'b0};
   assign erode_last = step_ff == (er_rows_ff + ROW_CW'(1));

   always_comb begin
      logic [2:0] sea;
      for (int c = 0; c < MAX_COLS; c++) begin
         sea = {2'b00, !up_row[c]} + {2'b00, !down_row[c]}
             + {2'b00, !mid_pad[c]} + {2'b00, !mid_pad[c + 2]};
         surv_row[c] = mid_ff[c] && (sea <= SEA_MAX);
      end
   end

   // column bounds: one column of the survivor union per cycle
   assign hit       = union_ff[scan_ff];
   assign col_lo_nx = (hit && !col_found_ff) ? scan_ff : col_lo_ff;
   assign col_hi_nx = hit ? scan_ff : col_hi_ff;
   assign scan_last = (COL_CW'(scan_ff) + COL_CW'(1)) == er_cols_ff;

   // cropped readout
   assign empty   = !frame_ready_ff || !box_valid_ff;
   assign rd_cell = surv_rd_ff[read_col_ff];
   assign eor     = read_col_ff >= col_hi_ff;
   assign fin     = eor && (read_row_ff >= row_hi_ff);

   always_comb begin
      load_row_in    = load_row_ff;
      load_col_in    = load_col_ff;
      er_rows_in     = er_rows_ff;
      er_cols_in     = er_cols_ff;
      step_in        = step_ff;
      up_in          = up_ff;
      mid_in         = mid_ff;
      union_in       = union_ff;
      box_valid_in   = box_valid_ff;
      row_lo_in      = row_lo_ff;
      row_hi_in      = row_hi_ff;
      scan_in        = scan_ff;
      col_found_in   = col_found_ff;
      col_lo_in      = col_lo_ff;
      col_hi_in      = col_hi_ff;
      frame_ready_in = frame_ready_ff;
      read_row_in    = read_row_ff;
      read_col_in    = read_col_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_cell_in    = rsp_cell_ff;
      rsp_eor_in     = rsp_eor_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_empty_in   = rsp_empty_ff;

      if (cmd.load) begin
         frame_ready_in = 1'b0;
         if (frame_full) begin
            load_row_in = '0;
            load_col_in = '0;
         end else if (wrap) begin
            load_row_in = ROW_AW'(row_next);
            load_col_in = '0;
         end else begin
            load_col_in = COL_AW'(col_next);
         end
      end

      if (cmd.erode_start) begin
         er_rows_in   = eff_rows;
         er_cols_in   = eff_cols;
         step_in      = '0;
         union_in     = '0;
         box_valid_in = 1'b0;
         scan_in      = '0;
         col_found_in = 1'b0;
      end

      if (cmd.erode_step) begin
         step_in = step_ff + ROW_CW'(1);
         up_in   = mid_ff;
         mid_in  = down_row;
         if (calc_en && (surv_row != '0)) begin
            union_in     = union_ff | surv_row;
            box_valid_in = 1'b1;
            row_hi_in    = calc_row[ROW_AW-1:0];
            if (!box_valid_ff) begin
               row_lo_in = calc_row[ROW_AW-1:0];
            end
         end
      end

      if (cmd.scan_step) begin
         scan_in      = scan_ff + COL_AW'(1);
         col_found_in = col_found_ff || hit;
         col_lo_in    = col_lo_nx;
         col_hi_in    = col_hi_nx;
         if (scan_last) begin
            frame_ready_in = 1'b1;
            read_row_in    = row_lo_ff;
            read_col_in    = col_lo_nx;
         end
      end

      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
         if (empty) begin
            rsp_cell_in  = 1'b0;
            rsp_eor_in   = 1'b0;
            rsp_last_in  = 1'b0;
            rsp_empty_in = 1'b1;
         end else begin
            rsp_cell_in  = rd_cell;
            rsp_eor_in   = eor;
            rsp_last_in  = fin;
            rsp_empty_in = 1'b0;
            if (fin) begin
               frame_ready_in = 1'b0;
               read_row_in    = row_lo_ff;
               read_col_in    = col_lo_ff;
            end else if (eor) begin
               read_row_in = read_row_ff + ROW_AW'(1);
               read_col_in = col_lo_ff;
            end else begin
               read_col_in = read_col_ff + COL_AW'(1);
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         land_mem[load_row_ff][load_col_ff] <= req_land;
      end
      if (rd_en) begin
         land_rd_ff <= land_mem[step_ff[ROW_AW-1:0]];
      end
      if (calc_en) begin
         surv_mem[calc_row[ROW_AW-1:0]] <= surv_row;
      end
      surv_rd_ff <= surv_mem[read_row_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff    <= '0;
         load_col_ff    <= '0;
         step_ff        <= '0;
         box_valid_ff   <= 1'b0;
         scan_ff        <= '0;
         col_found_ff   <= 1'b0;
         frame_ready_ff <= 1'b0;
         read_row_ff    <= '0;
         read_col_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         load_row_ff    <= load_row_in;
         load_col_ff    <= load_col_in;
         step_ff        <= step_in;
         box_valid_ff   <= box_valid_in;
         scan_ff        <= scan_in;
         col_found_ff   <= col_found_in;
         frame_ready_ff <= frame_ready_in;
         read_row_ff    <= read_row_in;
         read_col_ff    <= read_col_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.erode_start) begin
         col_mask_ff <= col_mask_in;
      end
      er_rows_ff   <= er_rows_in;
      er_cols_ff   <= er_cols_in;
      up_ff        <= up_in;
      mid_ff       <= mid_in;
      union_ff     <= union_in;
      row_lo_ff    <= row_lo_in;
      row_hi_ff    <= row_hi_in;
      col_lo_ff    <= col_lo_in;
      col_hi_ff    <= col_hi_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_eor_ff   <= rsp_eor_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign sts.frame_full = frame_full;
   assign sts.erode_last = erode_last;
   assign sts.scan_last  = scan_last;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell  = rsp_cell_ff;
   assign rsp_eor   = rsp_eor_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_empty = rsp_empty_ff;

endmodule

>>> design/binary_map_erode_and_crop_unit.sv
// Binary map erode and crop unit: loads a land/sea map of map_rows by map_cols cells in raster
// order, keeps each land cell with at most two sea neighbors (outside the map is sea), and
// returns the survivors cropped to their bounding box, one cell per read request. A load is
// taken in the idle state; a read passes through the read state, and its cell comes from the
// registered read of the survivor memory. The load that completes a frame starts an erosion
// sweep (one land memory row read per cycle into a three row window) and a column scan that
// finds the crop columns; no request is taken during them. Requests also wait while an
// earlier response is still held in the output register.
module binary_map_erode_and_crop_unit #(
   parameter int MAX_ROWS = bmec_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bmec_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bmec_pkg::REQ_DATA_W-1:0] req_tdata,   // [0] land
   input  logic                            req_tuser,   // [0] operation
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bmec_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [0] cell_land, [1] end_of_row
   output logic                            rsp_tlast,
   output logic                            rsp_tuser,   // [0] empty_res
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bmec_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bmec_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bmec_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import bmec_pkg::*;

   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic             csr_wr;
   logic             csr_idx;
   cmd_type          cmd;
   sts_type          sts;
   logic             rsp_cell;
   logic             rsp_eor;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_IDX_ROWS: rows_in = csr_pwdata[DIM_W-1:0];
            CSR_IDX_COLS: cols_in = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_ROWS: csr_prdata = CSR_DATA_W'(rows_ff);
         CSR_IDX_COLS: csr_prdata = CSR_DATA_W'(cols_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_RESET;
         cols_ff <= DIM_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   bmec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   bmec_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg_rows  (rows_ff),
      .cfg_cols  (cols_ff),
      .req_land  (req_tdata[0]),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_cell  (rsp_cell),
      .rsp_eor   (rsp_eor),
      .rsp_last  (rsp_tlast),
      .rsp_empty (rsp_tuser)
   );

   assign rsp_tdata = {(RSP_DATA_W - 2)'(0), rsp_eor, rsp_cell};

endmodule

>>> tb/sv/tb_binary_map_erode_and_crop_unit.sv
// self-checking testbench for the binary map erode and crop unit: loads and reads with a predictor
module tb_binary_map_erode_and_crop_unit;
   import bmec_pkg::*;

   localparam int GRID_ROWS     = DEF_MAX_ROWS;
   localparam int GRID_COLS     = DEF_MAX_COLS;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT   = 4000;
   localparam int ITEM_TARGET   = 1050;

   typedef struct packed {
      logic op;
      logic land;
   } map_request;

   typedef struct packed {
      logic cell_land;
      logic end_of_row;
      logic last;
      logic empty_res;
   } crop_cell;

   typedef enum int {SENDER_LIGHT_GAPS, SENDER_HEAVY_GAPS, NO_GAPS} gap_mode_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   binary_map_erode_and_crop_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   map_request       pending[$];
   crop_cell         crop_expect[$];
   map_request       in_flight;
   gap_mode_t        gap_mode = SENDER_LIGHT_GAPS;
   int               pushed = 0;
   int               error_count = 0;
   int               stall_cycles = 0;

   // predictor state
   logic [DIM_W-1:0]     rows_cfg = DIM_RESET;
   logic [DIM_W-1:0]     cols_cfg = DIM_RESET;
   logic [GRID_COLS-1:0] land_grid [GRID_ROWS];
   logic [GRID_COLS-1:0] keep_grid [GRID_ROWS];
   int                   fill_row = 0;
   int                   fill_col = 0;
   logic                 box_valid = 1'b0;
   int                   box_row_lo = 0;
   int                   box_row_hi = 0;
   int                   box_col_lo = 0;
   int                   box_col_hi = 0;
   int                   scan_row = 0;
   int                   scan_col = 0;
   logic                 crop_pending = 1'b0;

   function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
      if (v == '0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic logic land_bit(input int r, input int c);
      if (r < 0 || c < 0 || r >= GRID_ROWS || c >= GRID_COLS) return 1'b0;
      return land_grid[r][c];
   endfunction

   task automatic erode_grid(input int rows, input int cols);
      int sea;
      box_valid = 1'b0;
      box_row_lo = 0;
      box_row_hi = 0;
      box_col_lo = 0;
      box_col_hi = 0;
      for (int r = 0; r < GRID_ROWS; r++) keep_grid[r] = '0;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            if (!land_bit(r, c)) continue;
            sea = 0;
            if (r == 0 || !land_bit(r - 1, c)) sea++;
            if (r + 1 >= rows || !land_bit(r + 1, c)) sea++;
            if (c == 0 || !land_bit(r, c - 1)) sea++;
            if (c + 1 >= cols || !land_bit(r, c + 1)) sea++;
            if (sea <= int'(SEA_MAX)) begin
               keep_grid[r][c] = 1'b1;
               if (!box_valid) begin
                  box_valid = 1'b1;
                  box_row_lo = r;
                  box_row_hi = r;
                  box_col_lo = c;
                  box_col_hi = c;
               end else begin
                  if (r < box_row_lo) box_row_lo = r;
                  if (r > box_row_hi) box_row_hi = r;
                  if (c < box_col_lo) box_col_lo = c;
                  if (c > box_col_hi) box_col_hi = c;
               end
            end
         end
      end
      scan_row = box_row_lo;
      scan_col = box_col_lo;
      crop_pending = 1'b1;
   endtask

   task automatic apply_request(input map_request rq);
      int       rows;
      int       cols;
      crop_cell res;
      logic     eor;
      logic     fin;
      rows = clamp_dim(rows_cfg, GRID_ROWS);
      cols = clamp_dim(cols_cfg, GRID_COLS);
      if (rq.op == OP_LOAD) begin
         crop_pending = 1'b0;
         if (fill_row < GRID_ROWS && fill_col < GRID_COLS) land_grid[fill_row][fill_col] = rq.land;
         fill_col++;
         if (fill_col >= cols) begin
            fill_col = 0;
            fill_row++;
         end
         if (fill_row >= rows) begin
            fill_row = 0;
            fill_col = 0;
            erode_grid(rows, cols);
         end
      end else if (!crop_pending || !box_valid) begin
         res = '{cell_land: 1'b0, end_of_row: 1'b0, last: 1'b0, empty_res: 1'b1};
         crop_expect.push_back(res);
      end else begin
         eor = (scan_col >= box_col_hi);
         fin = eor && (scan_row >= box_row_hi);
         res.cell_land = (scan_row < GRID_ROWS && scan_col < GRID_COLS) ?
                         keep_grid[scan_row][scan_col] : 1'b0;
         res.end_of_row = eor;
         res.last = fin;
         res.empty_res = 1'b0;
         crop_expect.push_back(res);
         if (fin) begin
            crop_pending = 1'b0;
            scan_row = box_row_lo;
            scan_col = box_col_lo;
         end else if (eor) begin
            scan_col = box_col_lo;
            scan_row++;
         end else begin
            scan_col++;
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      int         send_gap;
      map_request nxt;
      send_gap = (gap_mode == SENDER_LIGHT_GAPS) ? 19 : (gap_mode == SENDER_HEAVY_GAPS) ? 57 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_request(in_flight);
         if (!req_tvalid || req_tready) begin
            if (pending.size() > 0 && $urandom_range(0, 99) >= send_gap) begin
               nxt = pending.pop_front();
               in_flight = nxt;
               req_tvalid <= 1'b1;
               req_tuser <= nxt.op;
               req_tdata <= {{(REQ_DATA_W-1){1'b0}}, nxt.land};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      int       rcv_gap;
      crop_cell exp_cell;
      rcv_gap = (gap_mode == SENDER_LIGHT_GAPS) ? 57 : (gap_mode == SENDER_HEAVY_GAPS) ? 19 : 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (crop_expect.size() == 0) begin
               $error("unexpected response: cell_land %0b end_of_row %0b last %0b empty_res %0b",
                      rsp_tdata[0], rsp_tdata[1], rsp_tlast, rsp_tuser);
               error_count++;
            end else begin
               exp_cell = crop_expect.pop_front();
               if (rsp_tdata[0] !== exp_cell.cell_land) begin
                  $error("cell_land expected %0b actual %0b", exp_cell.cell_land, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[1] !== exp_cell.end_of_row) begin
                  $error("end_of_row expected %0b actual %0b", exp_cell.end_of_row, rsp_tdata[1]);
                  error_count++;
               end
               if (rsp_tlast !== exp_cell.last) begin
                  $error("last expected %0b actual %0b", exp_cell.last, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser !== exp_cell.empty_res) begin
                  $error("empty_res expected %0b actual %0b", exp_cell.empty_res, rsp_tuser);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rcv_gap);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("binary_map_erode_and_crop_unit verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic csr_write(input logic idx, input logic [DIM_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == CSR_IDX_ROWS) rows_cfg = value;
      else cols_cfg = value;
   endtask

   // wait until the block has drained and any erosion sweep is over
   task automatic settle();
      while (pending.size() != 0 || req_tvalid || crop_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] rows_v, input logic [DIM_W-1:0] cols_v);
      settle();
      gap_mode = (pushed < ITEM_TARGET / 3) ? SENDER_LIGHT_GAPS :
                 (pushed < 2 * ITEM_TARGET / 3) ? SENDER_HEAVY_GAPS : NO_GAPS;
      csr_write(CSR_IDX_ROWS, rows_v);
      csr_write(CSR_IDX_COLS, cols_v);
   endtask

   task automatic push_request(input logic op, input logic land);
      map_request rq;
      rq.op = op;
      rq.land = land;
      pending.push_back(rq);
      pushed++;
   endtask

   task automatic push_reads(input int count);
      for (int i = 0; i < count; i++) push_request(OP_READ, 1'($urandom));
   endtask

   task automatic push_frame(input int count, input int density, input int read_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < read_pct) push_request(OP_READ, 1'($urandom));
         push_request(OP_LOAD, 1'($urandom_range(0, 99) < density));
      end
   endtask

   function automatic logic [DIM_W-1:0] pick_dim();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return DIM_W'($urandom_range(1, 6));
      if (roll == 7) return '0;
      if (roll == 8) return DIM_W'($urandom_range(17, 31));
      return DIM_W'($urandom_range(7, 16));
   endfunction

   task automatic random_phase();
      int area;
      logic [DIM_W-1:0] rows_v;
      logic [DIM_W-1:0] cols_v;
      rows_v = pick_dim();
      cols_v = pick_dim();
      set_dims(rows_v, cols_v);
      area = clamp_dim(rows_v, GRID_ROWS) * clamp_dim(cols_v, GRID_COLS);
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 5) == 0) push_reads($urandom_range(1, 3));
         push_frame(area, $urandom_range(20, 95), ($urandom_range(0, 3) == 0) ? 10 : 0);
         push_reads($urandom_range(0, area + 2));
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) push_request(1'($urandom), 1'($urandom));
         end
      end
      // sometimes leave a partial frame so the next setting lands mid-frame
      if ($urandom_range(0, 3) == 0) push_frame($urandom_range(1, area), 60, 0);
   endtask

   initial begin
      for (int r = 0; r < GRID_ROWS; r++) begin
         land_grid[r] = '0;
         keep_grid[r] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: 2 by 2 map
      set_dims(5'd2, 5'd2);
      push_reads(1);
      push_frame(4, 100, 0);
      push_reads(2);
      for (int i = 0; i < 4; i++) push_request(OP_LOAD, 1'b0);
      push_reads(1);
      push_frame(4, 100, 0);
      push_reads(5);

      // full size frame writes every cell of the store
      set_dims(5'd16, 5'd16);
      push_frame(256, 75, 0);
      push_reads(40);

      set_dims(5'd0, 5'd0);
      push_frame(1, 100, 0);
      push_reads(2);
      push_frame(2, 50, 30);
      push_reads(2);

      set_dims(5'd31, 5'd1);
      push_frame(16, 80, 0);
      push_reads(18);

      set_dims(5'd1, 5'd31);
      push_frame(16, 80, 0);
      push_reads(18);

      set_dims(DIM_RESET, DIM_RESET);
      push_frame(100, 70, 5);
      push_reads(50);

      while (pushed < ITEM_TARGET) random_phase();

      settle();
      if (error_count == 0 && crop_expect.size() == 0) begin
         $display("binary_map_erode_and_crop_unit verification clean");
      end else begin
         $display("binary_map_erode_and_crop_unit verification failed");
      end
      $finish;
   end

endmodule
